// ===== rtl/dsfp_pkg.sv =====
package dsfp_pkg;

  localparam int unsigned PayloadLen = 29;
  localparam int unsigned IdxW       = 5;

  typedef enum logic [1:0] {
    PhHunt,
    PhLen,
    PhBody,
    PhTail
  } phase_e;

  typedef enum logic {
    CfgStartMarker = 1'b0,
    CfgEndMarker   = 1'b1
  } cfg_idx_e;

  localparam logic [7:0] StartMarkerRst = 8'hAA;
  localparam logic [7:0] EndMarkerRst   = 8'hBB;

  // Most significant field first, so the last field, declared_length, sits in the lowest bits
  typedef struct packed {
    logic        [15:0] supply_voltage;
    logic        [15:0] height_value;
    logic signed [31:0] speed_z;
    logic signed [31:0] speed_y;
    logic signed [31:0] speed_x;
    logic signed [31:0] yaw_angle;
    logic signed [31:0] roll_angle;
    logic signed [31:0] pitch_angle;
    logic        [7:0]  flight_state;
    logic        [7:0]  declared_length;
  } record_t;

  typedef struct packed {
    logic valid;
    logic advance;
  } step_t;

  typedef struct packed {
    logic   fire;
    phase_e phase;
  } status_t;

endpackage

// ===== rtl/dsfp_parser.sv =====
module dsfp_parser #(
  parameter int unsigned MarkerLen = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dsfp_pkg::step_t   step_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [7:0]        start_marker_i,
  input  logic [7:0]        end_marker_i,
  output dsfp_pkg::status_t status_o,
  output dsfp_pkg::record_t record_o
);

  localparam int unsigned RunW    = $clog2(MarkerLen + 1);
  localparam int unsigned StoreLen = dsfp_pkg::PayloadLen - 1;

  dsfp_pkg::phase_e            phase_q, phase_d;
  logic [RunW-1:0]             run_q, run_d;
  logic [dsfp_pkg::IdxW-1:0]   idx_q, idx_d;
  logic [7:0]                  len_q, len_d;
  logic [7:0]                  payload_q [StoreLen];
  logic [8*dsfp_pkg::PayloadLen-1:0] flat;
  logic                        take;
  logic                        run_done;
  logic                        last_byte;

  assign take      = step_i.valid && step_i.advance;
  assign run_done  = (run_q == RunW'(MarkerLen - 1));
  assign last_byte = (idx_q == dsfp_pkg::IdxW'(dsfp_pkg::PayloadLen - 1));

  always_comb begin
    phase_d = phase_q;
    run_d   = run_q;
    idx_d   = idx_q;
    len_d   = len_q;
    if (take) begin
      unique case (phase_q)
        dsfp_pkg::PhHunt: begin
          if (rx_byte_i == start_marker_i) begin
            if (run_done) begin
              run_d   = '0;
              phase_d = dsfp_pkg::PhLen;
            end else begin
              run_d = run_q + RunW'(1);
            end
          end else begin
            run_d = '0;
          end
        end
        dsfp_pkg::PhLen: begin
          len_d   = rx_byte_i;
          idx_d   = '0;
          phase_d = dsfp_pkg::PhBody;
        end
        dsfp_pkg::PhBody: begin
          if (last_byte) begin
            idx_d   = '0;
            run_d   = '0;
            phase_d = dsfp_pkg::PhTail;
          end else begin
            idx_d = idx_q + dsfp_pkg::IdxW'(1);
          end
        end
        dsfp_pkg::PhTail: begin
          if (rx_byte_i == end_marker_i) begin
            if (run_done) begin
              run_d   = '0;
              phase_d = dsfp_pkg::PhHunt;
            end else begin
              run_d = run_q + RunW'(1);
            end
          end else begin
            run_d = '0;
          end
        end
        default: phase_d = dsfp_pkg::PhHunt;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dsfp_pkg::PhHunt;
      run_q   <= '0;
      idx_q   <= '0;
      len_q   <= '0;
    end else begin
      phase_q <= phase_d;
      run_q   <= run_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
    end
  end

  // Shift payload bytes in from the top; when the last byte arrives, entry 0 holds byte 0
  always_ff @(posedge clk_i) begin
    if (take && phase_q == dsfp_pkg::PhBody) begin
      for (int unsigned i = 0; i < StoreLen - 1; i++) begin
        payload_q[i] <= payload_q[i+1];
      end
      payload_q[StoreLen-1] <= rx_byte_i;
    end
  end

  always_comb begin
    flat[8*StoreLen +: 8] = rx_byte_i;
    for (int unsigned i = 0; i < StoreLen; i++) begin
      flat[8*i +: 8] = payload_q[i];
    end
  end

  always_comb begin
    status_o.fire  = step_i.valid && (phase_q == dsfp_pkg::PhBody) && last_byte;
    status_o.phase = phase_q;

    record_o.declared_length = len_q;
    record_o.flight_state    = flat[7:0];
    record_o.pitch_angle     = flat[8*1  +: 32];
    record_o.roll_angle      = flat[8*5  +: 32];
    record_o.yaw_angle       = flat[8*9  +: 32];
    record_o.speed_x         = flat[8*13 +: 32];
    record_o.speed_y         = flat[8*17 +: 32];
    record_o.speed_z         = flat[8*21 +: 32];
    record_o.height_value    = flat[8*25 +: 16];
    record_o.supply_voltage  = flat[8*27 +: 16];
  end

endmodule

// ===== rtl/delimited_state_frame_parser_core.sv =====
// Path: the last payload byte passes the input register, then the result register,
// before its record appears on the output.
// Throughput: one byte per cycle; the input side stalls only while a finished
// record waits in the result register and the registered byte completes another.
// Reset: phase returns to the start-marker hunt, counters and length clear,
// markers return to 0xAA and 0xBB; the payload store is not cleared.
module delimited_state_frame_parser_core #(
  parameter int unsigned MARKER_LEN = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] declared_length, [15:8] flight_state, [47:16] pitch_angle,
  // [79:48] roll_angle, [111:80] yaw_angle, [143:112] speed_x,
  // [175:144] speed_y, [207:176] speed_z, [223:208] height_value,
  // [239:224] supply_voltage
  output logic [239:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [7:0]   cfg_wdata_i
);

  logic [7:0]        start_marker_q, end_marker_q;
  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              out_valid_q, out_valid_d;
  dsfp_pkg::record_t record_q, record;
  dsfp_pkg::step_t   step;
  dsfp_pkg::status_t status;
  logic              out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= dsfp_pkg::StartMarkerRst;
      end_marker_q   <= dsfp_pkg::EndMarkerRst;
    end else if (cfg_we_i) begin
      unique case (dsfp_pkg::cfg_idx_e'(cfg_index_i))
        dsfp_pkg::CfgStartMarker: start_marker_q <= cfg_wdata_i;
        dsfp_pkg::CfgEndMarker:   end_marker_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  // Hold the registered byte only when it completes a record and the output holds one not being taken
  assign step.valid    = in_valid_q;
  assign step.advance  = !status.fire || out_free;
  assign s_axis_tready = !in_valid_q || step.advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  dsfp_parser #(
    .MarkerLen(MARKER_LEN)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .rx_byte_i     (in_byte_q),
    .start_marker_i(start_marker_q),
    .end_marker_i  (end_marker_q),
    .status_o      (status),
    .record_o      (record)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = status.fire;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (status.fire && out_free) begin
      record_q <= record;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = record_q;

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a waiting record");

  a_fire_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.fire |-> (in_valid_q && status.phase == dsfp_pkg::PhBody))
    else $error("record completed outside the payload phase");

  a_fire_to_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.fire && step.advance) |=> (status.phase == dsfp_pkg::PhTail && out_valid_q))
    else $error("completed record not followed by end search and output");

endmodule

// ===== sim/delimited_state_frame_parser_core_test.sv =====
module delimited_state_frame_parser_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MarkerLen  = 4;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;

  // Mirrors the parser: tracks phase, marker runs and payload, and queues
  // the record each completed payload should produce.
  class telemetry_scoreboard;
    logic [7:0]          start_marker;
    logic [7:0]          end_marker;
    dsfp_pkg::phase_e    phase;
    int unsigned         run_len;
    int unsigned         body_pos;
    logic [7:0]          length_byte;
    logic [7:0]          body[dsfp_pkg::PayloadLen];
    dsfp_pkg::record_t   expected_records[$];
    int unsigned         mismatches;

    function new();
      start_marker = dsfp_pkg::StartMarkerRst;
      end_marker   = dsfp_pkg::EndMarkerRst;
      phase        = dsfp_pkg::PhHunt;
      run_len      = 0;
      body_pos     = 0;
      length_byte  = '0;
      mismatches   = 0;
    endfunction

    function void set_marker(dsfp_pkg::cfg_idx_e idx, logic [7:0] value);
      if (idx == dsfp_pkg::CfgStartMarker) begin
        start_marker = value;
      end else begin
        end_marker = value;
      end
    endfunction

    function void note_rx_byte(logic [7:0] b);
      dsfp_pkg::record_t rec;
      case (phase)
        dsfp_pkg::PhHunt: begin
          if (b == start_marker) begin
            run_len++;
            if (run_len >= MarkerLen) begin
              run_len = 0;
              phase   = dsfp_pkg::PhLen;
            end
          end else begin
            run_len = 0;
          end
        end
        dsfp_pkg::PhLen: begin
          length_byte = b;
          body_pos    = 0;
          phase       = dsfp_pkg::PhBody;
        end
        dsfp_pkg::PhBody: begin
          body[body_pos] = b;
          body_pos++;
          if (body_pos >= dsfp_pkg::PayloadLen) begin
            body_pos            = 0;
            run_len             = 0;
            phase               = dsfp_pkg::PhTail;
            rec.declared_length = length_byte;
            rec.flight_state    = body[0];
            rec.pitch_angle     = {body[4], body[3], body[2], body[1]};
            rec.roll_angle      = {body[8], body[7], body[6], body[5]};
            rec.yaw_angle       = {body[12], body[11], body[10], body[9]};
            rec.speed_x         = {body[16], body[15], body[14], body[13]};
            rec.speed_y         = {body[20], body[19], body[18], body[17]};
            rec.speed_z         = {body[24], body[23], body[22], body[21]};
            rec.height_value    = {body[26], body[25]};
            rec.supply_voltage  = {body[28], body[27]};
            expected_records.push_back(rec);
          end
        end
        default: begin
          if (b == end_marker) begin
            run_len++;
            if (run_len >= MarkerLen) begin
              run_len = 0;
              phase   = dsfp_pkg::PhHunt;
            end
          end else begin
            run_len = 0;
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_record(dsfp_pkg::record_t got);
      dsfp_pkg::record_t want;
      if (expected_records.size() == 0) begin
        $error("record delivered with none outstanding: %0h", got);
        mismatches++;
        return;
      end
      want = expected_records.pop_front();
      compare_field("declared_length", want.declared_length, got.declared_length);
      compare_field("flight_state", want.flight_state, got.flight_state);
      compare_field("pitch_angle", want.pitch_angle, got.pitch_angle);
      compare_field("roll_angle", want.roll_angle, got.roll_angle);
      compare_field("yaw_angle", want.yaw_angle, got.yaw_angle);
      compare_field("speed_x", want.speed_x, got.speed_x);
      compare_field("speed_y", want.speed_y, got.speed_y);
      compare_field("speed_z", want.speed_z, got.speed_z);
      compare_field("height_value", want.height_value, got.height_value);
      compare_field("supply_voltage", want.supply_voltage, got.supply_voltage);
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;   // [7:0] rx_byte
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // [7:0] declared_length, [15:8] flight_state, [47:16] pitch_angle,
  // [79:48] roll_angle, [111:80] yaw_angle, [143:112] speed_x,
  // [175:144] speed_y, [207:176] speed_z, [223:208] height_value,
  // [239:224] supply_voltage
  logic [239:0] m_axis_tdata;
  logic         cfg_we_i;
  logic         cfg_index_i;
  logic [7:0]   cfg_wdata_i;

  telemetry_scoreboard sb;

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned bytes_sent;
  int unsigned hold_requests;
  int unsigned holds_served;
  int unsigned hold_left;
  int unsigned cycles;

  delimited_state_frame_parser_core #(
    .MARKER_LEN(MarkerLen)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      sb.note_rx_byte(s_axis_tdata);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_record(dsfp_pkg::record_t'(m_axis_tdata));
    end
  end

  // Receiver: random stalls, or a long hold-off once requested
  always @(negedge clk_i) begin
    if (hold_requests != holds_served) begin
      holds_served++;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $error("timed out with %0d records outstanding", sb.expected_records.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic write_marker(input dsfp_pkg::cfg_idx_e idx, input logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_marker(idx, value);
  endtask

  // Wait for every outstanding record, then let the pipeline settle
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_records.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] other_than(logic [7:0] m);
    logic [7:0] b;
    b = 8'($urandom);
    if (b == m) b = ~m;
    return b;
  endfunction

  function automatic logic [7:0] body_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_frame();
    logic [7:0] s;
    logic [7:0] e;
    s = sb.start_marker;
    e = sb.end_marker;
    // noise and broken start runs in the hunt
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(5, 20)) send_byte(8'($urandom));
    end
    repeat ($urandom_range(2)) send_byte(8'($urandom));
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, MarkerLen - 1)) send_byte(s);
      send_byte(other_than(s));
    end
    // an overlong run makes the marker value the length byte
    repeat (MarkerLen + ($urandom_range(4) == 0)) send_byte(s);
    send_byte(body_byte());
    repeat (dsfp_pkg::PayloadLen) send_byte(body_byte());
    repeat ($urandom_range(2)) send_byte(other_than(e));
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, MarkerLen - 1)) send_byte(e);
      send_byte(other_than(e));
    end
    repeat (MarkerLen) send_byte(e);
  endtask

  task automatic send_directed(input logic [7:0] len, input logic invert);
    logic [7:0] body[dsfp_pkg::PayloadLen];
    body = '{8'hFF,
             8'h00, 8'h00, 8'h00, 8'h80,
             8'hFF, 8'hFF, 8'hFF, 8'h7F,
             8'hFF, 8'hFF, 8'hFF, 8'hFF,
             8'h00, 8'h00, 8'h00, 8'h00,
             8'h01, 8'h00, 8'h00, 8'h00,
             8'hFE, 8'hFF, 8'hFF, 8'hFF,
             8'hFF, 8'hFF,
             8'h00, 8'h00};
    repeat (MarkerLen - 1) send_byte(sb.start_marker);
    send_byte(other_than(sb.start_marker));
    repeat (MarkerLen) send_byte(sb.start_marker);
    send_byte(len);
    foreach (body[i]) send_byte(invert ? ~body[i] : body[i]);
    repeat (MarkerLen - 2) send_byte(sb.end_marker);
    send_byte(other_than(sb.end_marker));
    repeat (MarkerLen) send_byte(sb.end_marker);
  endtask

  initial begin
    int unsigned target;
    sb            = new();
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = dsfp_pkg::CfgStartMarker;
    cfg_wdata_i   = '0;
    idle_pct      = 0;
    stall_pct     = 0;
    bytes_sent    = 0;
    hold_requests = 0;
    holds_served  = 0;
    hold_left     = 0;
    cycles        = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 47;
          stall_pct = 0;
          write_marker(dsfp_pkg::CfgStartMarker, 8'h00);
          write_marker(dsfp_pkg::CfgEndMarker, 8'hFF);
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 47;
          write_marker(dsfp_pkg::CfgStartMarker, 8'hFF);
          write_marker(dsfp_pkg::CfgEndMarker, 8'h00);
        end
        default: begin
          idle_pct  = 21;
          stall_pct = 21;
          write_marker(dsfp_pkg::CfgStartMarker, 8'($urandom));
          write_marker(dsfp_pkg::CfgEndMarker, 8'($urandom));
        end
      endcase
      if (p == 0) begin
        // length byte equal to the marker, then all-zero length with inverted payload, then 0xFF length
        send_directed(sb.start_marker, 1'b0);
        send_directed(8'h00, 1'b1);
        send_directed(8'hFF, 1'b0);
        hold_requests++;
      end
      target = bytes_sent + 230;
      while (bytes_sent < target) send_frame();
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (sb.expected_records.size() != 0) begin
      $error("%0d records never delivered", sb.expected_records.size());
    end
    if (sb.mismatches == 0 && sb.expected_records.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
